@@ sv/fct_pkg.sv @@
// types, constants and lookup functions shared by the codon translator modules
`default_nettype none

package fct_pkg;

    // ascii codes the front end tests for
    localparam logic [7:0] CHAR_LF = 8'h0A;

    // codon queue sizing
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

    // line of the four-line record
    typedef enum logic [1:0] {
        LINE_HEADER = 2'd0,
        LINE_SEQ    = 2'd1,
        LINE_SEP    = 2'd2,
        LINE_QUAL   = 2'd3
    } line_t;

    // base codes
    typedef enum logic [1:0] {
        BASE_A = 2'd0,
        BASE_C = 2'd1,
        BASE_G = 2'd2,
        BASE_T = 2'd3
    } base_t;

    // codon index: first base in the top bits
    typedef logic [5:0] codon_t;

    // front end to queue
    typedef struct packed {
        logic   valid;
        codon_t codon;
    } codon_push_t;

    // queue head towards the back end
    typedef struct packed {
        logic   valid;
        codon_t codon;
    } codon_head_t;

    // amino-acid letters, codon 0 in the leftmost character
    localparam logic [64*8-1:0] AMINO_STR =
        "KNKNTTTTRSRSIIMIQHQHPPPPRRRRLLLLEDEDAAAAGGGGVVVV-Y-YSSSS-CWCLFLF";

    // normalise a sequence byte to a base, anything unknown counts as A
    function automatic base_t base_code(input logic [7:0] b);
        base_t code;
        case (b) inside
            "C", "c":           code = BASE_C;
            "G", "g":           code = BASE_G;
            "T", "t", "U", "u": code = BASE_T;
            default:            code = BASE_A;
        endcase
        return code;
    endfunction

    // standard genetic code, '-' for stop codons
    function automatic logic [7:0] amino_char(input codon_t codon);
        logic [8:0] offset;
        offset = {~codon, 3'b000};
        return AMINO_STR[offset +: 8];
    endfunction

endpackage

`default_nettype wire

@@ sv/fct_front.sv @@
// front end: record line tracking, base normalisation and codon packing
`default_nettype none

module fct_front
    import fct_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,
    input  wire logic        queue_full,
    output codon_push_t      push
);

    line_t       record_line_reg, record_line_next;
    logic [1:0]  base_count_reg, base_count_next;
    base_t       held0_reg, held0_next;
    base_t       held1_reg, held1_next;
    logic        accept;
    base_t       code;

    assign s_tready = ~queue_full;
    assign accept   = s_tvalid & s_tready;
    assign code     = base_code(s_tdata);

    // line tracking and codon assembly
    always_comb begin
        record_line_next = record_line_reg;
        base_count_next  = base_count_reg;
        held0_next       = held0_reg;
        held1_next       = held1_reg;
        push.valid       = 1'b0;
        push.codon       = {held0_reg, held1_reg, code};
        if (accept) begin
            if (s_tdata == CHAR_LF) begin
                record_line_next = line_t'(record_line_reg + 2'd1);
            end else if (record_line_reg == LINE_SEQ) begin
                case (base_count_reg)
                    2'd0: begin
                        held0_next      = code;
                        base_count_next = 2'd1;
                    end
                    2'd1: begin
                        held1_next      = code;
                        base_count_next = 2'd2;
                    end
                    default: begin
                        push.valid      = 1'b1;
                        base_count_next = 2'd0;
                    end
                endcase
            end
        end
    end

    // state registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            record_line_reg <= LINE_HEADER;
            base_count_reg  <= 2'd0;
            held0_reg       <= BASE_A;
            held1_reg       <= BASE_A;
        end else begin
            record_line_reg <= record_line_next;
            base_count_reg  <= base_count_next;
            held0_reg       <= held0_next;
            held1_reg       <= held1_next;
        end
    end

`ifndef ASSERT_OFF
    // the codon phase never reaches three
    assert property (@(posedge aclk) disable iff (!aresetn)
        base_count_reg != 2'd3)
        else $error("codon phase out of range");

    // a codon is only pushed from the sequence line
    assert property (@(posedge aclk) disable iff (!aresetn)
        push.valid |-> (record_line_reg == LINE_SEQ && base_count_reg == 2'd2))
        else $error("codon pushed outside the sequence line");

    // a newline always advances the record line
    assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && s_tdata == CHAR_LF) |=>
            record_line_reg == line_t'($past(record_line_reg) + 2'd1))
        else $error("record line did not advance on newline");
`endif

endmodule

`default_nettype wire

@@ sv/fct_queue.sv @@
// short codon queue between the front end and the back end
`default_nettype none

module fct_queue
    import fct_pkg::*;
(
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire codon_push_t  push,
    output logic              full,
    output codon_head_t       head,
    input  wire logic         pop
);

    codon_t                   mem [QUEUE_DEPTH];
    logic [QUEUE_PTR_W-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [QUEUE_CNT_W-1:0]   count_reg, count_next;
    logic                     do_push, do_pop;

    assign full       = (count_reg == QUEUE_CNT_W'(QUEUE_DEPTH));
    assign head.valid = (count_reg != '0);
    assign head.codon = mem[rd_ptr_reg];
    assign do_push    = push.valid & ~full;
    assign do_pop     = pop & head.valid;

    // occupancy
    always_comb begin
        count_next = count_reg;
        case ({do_push, do_pop})
            2'b10:   count_next = count_reg + QUEUE_CNT_W'(1);
            2'b01:   count_next = count_reg - QUEUE_CNT_W'(1);
            default: count_next = count_reg;
        endcase
    end

    // storage
    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem[wr_ptr_reg] <= push.codon;
        end
    end

    // pointers and count
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (do_push) begin
                wr_ptr_reg <= wr_ptr_reg + QUEUE_PTR_W'(1);
            end
            if (do_pop) begin
                rd_ptr_reg <= rd_ptr_reg + QUEUE_PTR_W'(1);
            end
            count_reg <= count_next;
        end
    end

`ifndef ASSERT_OFF
    // occupancy stays within the depth
    assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= QUEUE_CNT_W'(QUEUE_DEPTH))
        else $error("queue occupancy beyond depth");

    // the front end never pushes into a full queue
    assert property (@(posedge aclk) disable iff (!aresetn)
        !(push.valid && full))
        else $error("push into full queue");

    // pointer gap agrees with the count
    assert property (@(posedge aclk) disable iff (!aresetn)
        (wr_ptr_reg - rd_ptr_reg) == count_reg[QUEUE_PTR_W-1:0])
        else $error("queue pointers and count disagree");
`endif

endmodule

`default_nettype wire

@@ sv/fct_back.sv @@
// back end: genetic code lookup into the output register
`default_nettype none

module fct_back
    import fct_pkg::*;
(
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire codon_head_t  head,
    output logic              pop,
    output logic              m_tvalid,
    input  wire logic         m_tready,
    output logic [7:0]        m_tdata
);

    logic        m_tvalid_reg, m_tvalid_next;
    logic [7:0]  m_tdata_reg;

    // take the next codon when the output register is free or being drained
    assign pop      = head.valid & (~m_tvalid_reg | m_tready);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    always_comb begin
        m_tvalid_next = m_tvalid_reg;
        if (pop) begin
            m_tvalid_next = 1'b1;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
    end

    // output beat payload
    always_ff @(posedge aclk) begin
        if (pop) begin
            m_tdata_reg <= amino_char(head.codon);
        end
    end

    // output valid
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else begin
            m_tvalid_reg <= m_tvalid_next;
        end
    end

`ifndef ASSERT_OFF
    // a popped codon always shows up as a beat
    assert property (@(posedge aclk) disable iff (!aresetn)
        pop |=> m_tvalid_reg)
        else $error("popped codon not presented");

    // the output register is only reloaded once its beat has gone
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid_reg && !m_tready) |-> !pop)
        else $error("output overwritten while stalled");

    // an idle queue with a drained output leaves the channel idle
    assert property (@(posedge aclk) disable iff (!aresetn)
        (!head.valid && (!m_tvalid_reg || m_tready)) |=> !m_tvalid_reg)
        else $error("beat presented without a codon");
`endif

endmodule

`default_nettype wire

@@ sv/fastq_codon_translator_core.sv @@
// Translator of FASTQ sequence lines into amino-acid letters (standard genetic
// code, '-' for stop codons). One byte is taken per clock cycle; s_tready falls
// only when the four-entry codon queue is full, which happens only after the
// result side has held m_tready low. Newlines step through the four lines of
// each record and only sequence-line bytes count as bases; the codon phase
// carries across records. A result beat is stored in the codon queue when the
// byte that completes its codon is taken, then passes to the output register.
`default_nettype none

module fastq_codon_translator_core
    import fct_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // [7:0] in_byte
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [7:0]       m_tdata    // [7:0] amino_char
);

    codon_push_t  push;
    codon_head_t  head;
    logic         queue_full;
    logic         pop;

    // classify bytes and build codons
    fct_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .queue_full (queue_full),
        .push       (push)
    );

    // decoupling queue
    fct_queue u_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (push),
        .full    (queue_full),
        .head    (head),
        .pop     (pop)
    );

    // translate and present results
    fct_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .head     (head),
        .pop      (pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule

`default_nettype wire
